// ----- sv/vms_pkg.sv -----
package vms_pkg;

   // Vehicle states
   typedef enum logic [2:0] {
      ST_INIT      = 3'd0,
      ST_RUN       = 3'd1,
      ST_DEGRADED  = 3'd2,
      ST_LIMP      = 3'd3,
      ST_HALT      = 3'd4,
      ST_SHUTDOWN  = 3'd5
   } vms_state_type;

   // Event codes in table order
   typedef enum logic [3:0] {
      EV_PASS      = 4'd0,
      EV_FAIL      = 4'd1,
      EV_PEDAL_S   = 4'd2,
      EV_PEDAL_D   = 4'd3,
      EV_LINK_S    = 4'd4,
      EV_LINK_D    = 4'd5,
      EV_ESTOP     = 4'd6,
      EV_KILL      = 4'd7,
      EV_CLEARED   = 4'd8,
      EV_RESTORED  = 4'd9,
      EV_STOPPED   = 4'd10,
      EV_MOTOR     = 4'd11,
      EV_BRAKE     = 4'd12,
      EV_STEER     = 4'd13
   } vms_event_type;

   // Power modes
   typedef enum logic [2:0] {
      PM_STARTUP   = 3'd0,
      PM_RUN       = 3'd1,
      PM_DEGRADED  = 3'd2,
      PM_HALT      = 3'd3,
      PM_SHUTDOWN  = 3'd4
   } vms_power_type;

   localparam int unsigned NUM_LANES = 3;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_INIT_HOLD = 2'd0;
   localparam logic [1:0] REG_RECOVERY  = 2'd1;
   localparam logic [1:0] REG_CONFIRM   = 2'd2;

   // Link status codes
   localparam logic [1:0] LINK_OK      = 2'd0;
   localparam logic [1:0] LINK_TIMEOUT = 2'd1;

   // Configuration as seen by the rule chain
   typedef struct packed {
      logic [15:0] init_hold_ticks;
      logic [15:0] recovery_ticks;
      logic [7:0]  confirm_ticks;
   } vms_cfg_type;

   // Supervisor state carried from item to item
   typedef struct packed {
      logic [2:0]                mode;
      logic                      pass_pending;
      logic [15:0]               hold_count;
      logic [15:0]               clear_count;
      logic [NUM_LANES-1:0][7:0] confirm_count;
   } vms_ctx_type;

   // One result item
   typedef struct packed {
      logic [2:0] veh_state;
      logic [2:0] power_mode;
      logic       mode_requested;
      logic [2:0] fault_reported;
   } vms_rsp_type;

   // Running state of the transition chain within one item
   typedef struct packed {
      logic [2:0] mode;
      logic       pend;
      logic       req;
   } vms_fire_type;

   function automatic logic [3:0] go(input vms_state_type st);
      return {1'b1, st};
   endfunction

   // Transition table: bit3 = allowed, bits 2..0 = next state
   function automatic logic [3:0] next_entry(input logic [2:0] st, input logic [3:0] ev);
      logic [3:0] e;
      e = 4'd0;
      case (st)
         ST_INIT: begin
            case (ev)
               EV_PASS: e = go(ST_RUN);
               EV_FAIL: e = go(ST_HALT);
               EV_KILL: e = go(ST_HALT);
               default: e = 4'd0;
            endcase
         end
         ST_RUN: begin
            case (ev)
               EV_PEDAL_S: e = go(ST_DEGRADED);
               EV_PEDAL_D: e = go(ST_HALT);
               EV_LINK_S:  e = go(ST_LIMP);
               EV_LINK_D:  e = go(ST_HALT);
               EV_ESTOP:   e = go(ST_HALT);
               EV_KILL:    e = go(ST_HALT);
               EV_MOTOR:   e = go(ST_DEGRADED);
               EV_BRAKE:   e = go(ST_HALT);
               EV_STEER:   e = go(ST_HALT);
               default:    e = 4'd0;
            endcase
         end
         ST_DEGRADED: begin
            case (ev)
               EV_PEDAL_D: e = go(ST_HALT);
               EV_LINK_S:  e = go(ST_LIMP);
               EV_LINK_D:  e = go(ST_HALT);
               EV_ESTOP:   e = go(ST_HALT);
               EV_KILL:    e = go(ST_HALT);
               EV_CLEARED: e = go(ST_RUN);
               EV_MOTOR:   e = go(ST_HALT);
               EV_BRAKE:   e = go(ST_HALT);
               EV_STEER:   e = go(ST_HALT);
               default:    e = 4'd0;
            endcase
         end
         ST_LIMP: begin
            case (ev)
               EV_PEDAL_D:  e = go(ST_HALT);
               EV_LINK_D:   e = go(ST_HALT);
               EV_ESTOP:    e = go(ST_HALT);
               EV_KILL:     e = go(ST_HALT);
               EV_CLEARED:  e = go(ST_RUN);
               EV_RESTORED: e = go(ST_DEGRADED);
               EV_MOTOR:    e = go(ST_HALT);
               EV_BRAKE:    e = go(ST_HALT);
               EV_STEER:    e = go(ST_HALT);
               default:     e = 4'd0;
            endcase
         end
         ST_HALT: begin
            case (ev)
               EV_STOPPED: e = go(ST_SHUTDOWN);
               default:    e = 4'd0;
            endcase
         end
         default: e = 4'd0;
      endcase
      return e;
   endfunction

   // Apply one event; a self-test pass in INIT only marks it pending
   function automatic vms_fire_type fire_event(input vms_fire_type cur, input logic [3:0] ev);
      vms_fire_type r;
      logic [3:0]   e;
      r = cur;
      e = next_entry(cur.mode, ev);
      if (ev == EV_PASS && cur.mode == ST_INIT) begin
         r.pend = 1'b1;
      end else if (e[3]) begin
         r.mode = e[2:0];
         r.req  = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [2:0] power_of(input logic [2:0] st);
      logic [2:0] pm;
      case (st)
         ST_INIT:      pm = PM_STARTUP;
         ST_RUN:       pm = PM_RUN;
         ST_DEGRADED:  pm = PM_DEGRADED;
         ST_LIMP:      pm = PM_DEGRADED;
         ST_HALT:      pm = PM_HALT;
         ST_SHUTDOWN:  pm = PM_SHUTDOWN;
         default:      pm = PM_STARTUP;
      endcase
      return pm;
   endfunction

endpackage

// ----- sv/vms_csr.sv -----
module vms_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output vms_pkg::vms_cfg_type cfg
);

   logic [15:0] init_hold_ff;
   logic [15:0] recovery_ff;
   logic [7:0]  confirm_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   // Write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         init_hold_ff <= 16'd10;
         recovery_ff  <= 16'd50;
         confirm_ff   <= 8'd3;
      end else if (wr_en) begin
         case (paddr[3:2])
            vms_pkg::REG_INIT_HOLD: init_hold_ff <= pwdata[15:0];
            vms_pkg::REG_RECOVERY:  recovery_ff  <= pwdata[15:0];
            vms_pkg::REG_CONFIRM:   confirm_ff   <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (paddr[3:2])
         vms_pkg::REG_INIT_HOLD: prdata = {16'd0, init_hold_ff};
         vms_pkg::REG_RECOVERY:  prdata = {16'd0, recovery_ff};
         vms_pkg::REG_CONFIRM:   prdata = {24'd0, confirm_ff};
         default:                prdata = 32'd0;
      endcase
   end

   assign cfg.init_hold_ticks = init_hold_ff;
   assign cfg.recovery_ticks  = recovery_ff;
   assign cfg.confirm_ticks   = confirm_ff;

endmodule

// ----- sv/vms_rules.sv -----
module vms_rules (
   input  logic                 action,
   input  logic [3:0]           event_id,
   input  logic                 pedal_err,
   input  logic                 estop_on,
   input  logic [1:0]           front_link,
   input  logic [1:0]           rear_link,
   input  logic                 motor_cut,
   input  logic                 brake_err,
   input  logic                 steer_err,
   input  logic                 relay_kill,
   input  logic [1:0]           recheck_ok,
   input  vms_pkg::vms_cfg_type cfg,
   input  vms_pkg::vms_ctx_type ctx,
   output vms_pkg::vms_ctx_type ctx_next,
   output vms_pkg::vms_rsp_type rsp
);

   logic                      f_ok, r_ok, f_to, r_to, all_clear;
   logic [2:0]                lane_active, lane_recheck;
   logic [3:0]                lane_event [vms_pkg::NUM_LANES];
   vms_pkg::vms_fire_type     f;
   logic [15:0]               hold_v, clear_v;
   logic [vms_pkg::NUM_LANES-1:0][7:0] cnt_v;
   logic [7:0]                cnt_inc;
   logic [2:0]                faults;

   assign f_ok = (front_link == vms_pkg::LINK_OK);
   assign r_ok = (rear_link == vms_pkg::LINK_OK);
   assign f_to = (front_link == vms_pkg::LINK_TIMEOUT);
   assign r_to = (rear_link == vms_pkg::LINK_TIMEOUT);
   assign all_clear = ~estop_on & ~motor_cut & ~brake_err & ~steer_err
                    & ~pedal_err & ~relay_kill & f_ok & r_ok;

   assign lane_active   = {steer_err, brake_err, motor_cut};
   assign lane_recheck  = {1'b1, recheck_ok[1], recheck_ok[0]};
   assign lane_event[0] = vms_pkg::EV_MOTOR;
   assign lane_event[1] = vms_pkg::EV_BRAKE;
   assign lane_event[2] = vms_pkg::EV_STEER;

   // Walk the ordered rule chain for one item
   always_comb begin
      f       = '{mode: ctx.mode, pend: ctx.pass_pending, req: 1'b0};
      hold_v  = ctx.hold_count;
      clear_v = ctx.clear_count;
      cnt_v   = ctx.confirm_count;
      cnt_inc = 8'd0;
      faults  = 3'd0;
      if (action) begin
         f = vms_pkg::fire_event(f, event_id);
      end else begin
         // INIT hold and release
         if (f.mode == vms_pkg::ST_INIT) begin
            if (hold_v < cfg.init_hold_ticks) hold_v = hold_v + 16'd1;
            if (f.pend && hold_v >= cfg.init_hold_ticks && f_ok && r_ok) begin
               f.pend = 1'b0;
               f.mode = vms_pkg::ST_RUN;
               f.req  = 1'b1;
            end
         end
         if (estop_on) f = vms_pkg::fire_event(f, vms_pkg::EV_ESTOP);
         if (relay_kill) f = vms_pkg::fire_event(f, vms_pkg::EV_KILL);
         // Link timeout and restore
         if (f_to && r_to) begin
            f = vms_pkg::fire_event(f, vms_pkg::EV_LINK_D);
         end else if (f_to || r_to) begin
            if (f.mode == vms_pkg::ST_RUN || f.mode == vms_pkg::ST_DEGRADED)
               f = vms_pkg::fire_event(f, vms_pkg::EV_LINK_S);
         end else if (f.mode == vms_pkg::ST_LIMP) begin
            f = vms_pkg::fire_event(f, vms_pkg::EV_RESTORED);
         end
         // Pedal fault and clear
         if (f.mode == vms_pkg::ST_RUN && pedal_err)
            f = vms_pkg::fire_event(f, vms_pkg::EV_PEDAL_S);
         if (f.mode == vms_pkg::ST_DEGRADED && !pedal_err)
            f = vms_pkg::fire_event(f, vms_pkg::EV_CLEARED);
         // Debounce motor, brake, steering in that order
         for (int i = 0; i < vms_pkg::NUM_LANES; i++) begin
            if (lane_active[i]) begin
               cnt_inc = cnt_v[i] + 8'd1;
               if (cnt_inc >= cfg.confirm_ticks) begin
                  if (lane_recheck[i]) begin
                     faults[i] = 1'b1;
                     f = vms_pkg::fire_event(f, lane_event[i]);
                  end
                  cnt_v[i] = 8'd0;
               end else begin
                  cnt_v[i] = cnt_inc;
               end
            end else begin
               cnt_v[i] = 8'd0;
            end
         end
         // Timed recovery out of the halt state
         if (f.mode == vms_pkg::ST_HALT) begin
            if (all_clear) begin
               clear_v = clear_v + 16'd1;
               if (clear_v >= cfg.recovery_ticks) begin
                  clear_v = 16'd0;
                  f.mode  = vms_pkg::ST_INIT;
                  f.pend  = 1'b1;
                  f.req   = 1'b1;
               end
            end else begin
               clear_v = 16'd0;
            end
         end
      end
   end

   assign ctx_next.mode          = f.mode;
   assign ctx_next.pass_pending  = f.pend;
   assign ctx_next.hold_count    = hold_v;
   assign ctx_next.clear_count   = clear_v;
   assign ctx_next.confirm_count = cnt_v;

   assign rsp.veh_state      = f.mode;
   assign rsp.power_mode     = vms_pkg::power_of(f.mode);
   assign rsp.mode_requested = f.req;
   assign rsp.fault_reported = faults;

endmodule

// ----- sv/vehicle_mode_supervisor_core.sv -----
// Channel   Direction  Handshake                  Payload
// req_      in         req_valid / req_ready      action, event_id, fault signals, links
// rsp_      out        rsp_valid / rsp_ready      state, power mode, request flag, faults
// csr_      in         APB psel/penable, pready=1 three threshold registers
//
// An item is registered in the input register on acceptance, runs the rule chain once the
// result register is free or being emptied, and lands there, which raises rsp_valid.
// One item per cycle is sustained while rsp_ready is high; the input register can take an
// item while a result waits; req_ready drops only with both registers full and rsp_ready low.
// Synchronous reset puts the supervisor in INIT with all counters cleared.
module vehicle_mode_supervisor_core (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [3:0]  req_event_id,
   input  logic        req_pedal_err,
   input  logic        req_estop_on,
   input  logic [1:0]  req_front_link,
   input  logic [1:0]  req_rear_link,
   input  logic        req_motor_cut,
   input  logic        req_brake_err,
   input  logic        req_steer_err,
   input  logic        req_relay_kill,
   input  logic [1:0]  req_recheck_ok,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_veh_state,
   output logic [2:0]  rsp_power_mode,
   output logic        rsp_mode_requested,
   output logic [2:0]  rsp_fault_reported,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef struct packed {
      logic       action;
      logic [3:0] event_id;
      logic       pedal_err;
      logic       estop_on;
      logic [1:0] front_link;
      logic [1:0] rear_link;
      logic       motor_cut;
      logic       brake_err;
      logic       steer_err;
      logic       relay_kill;
      logic [1:0] recheck_ok;
   } item_type;

   vms_pkg::vms_cfg_type cfg;
   vms_pkg::vms_ctx_type ctx_ff, ctx_in;
   vms_pkg::vms_rsp_type rsp_ff, rsp_in;
   item_type             item_ff;
   logic                 item_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   vms_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Move the held item on when the result slot is free or being emptied
   assign advance   = item_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~item_valid_ff | advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= '{action: req_action, event_id: req_event_id,
                      pedal_err: req_pedal_err, estop_on: req_estop_on,
                      front_link: req_front_link, rear_link: req_rear_link,
                      motor_cut: req_motor_cut, brake_err: req_brake_err,
                      steer_err: req_steer_err, relay_kill: req_relay_kill,
                      recheck_ok: req_recheck_ok};
      end
   end

   vms_rules u_rules (
      .action     (item_ff.action),
      .event_id   (item_ff.event_id),
      .pedal_err  (item_ff.pedal_err),
      .estop_on   (item_ff.estop_on),
      .front_link (item_ff.front_link),
      .rear_link  (item_ff.rear_link),
      .motor_cut  (item_ff.motor_cut),
      .brake_err  (item_ff.brake_err),
      .steer_err  (item_ff.steer_err),
      .relay_kill (item_ff.relay_kill),
      .recheck_ok (item_ff.recheck_ok),
      .cfg        (cfg),
      .ctx        (ctx_ff),
      .ctx_next   (ctx_in),
      .rsp        (rsp_in)
   );

   // Supervisor state: advance once per processed item
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff <= '0;
      end else if (advance) begin
         ctx_ff <= ctx_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_veh_state      = rsp_ff.veh_state;
   assign rsp_power_mode     = rsp_ff.power_mode;
   assign rsp_mode_requested = rsp_ff.mode_requested;
   assign rsp_fault_reported = rsp_ff.fault_reported;

endmodule
